[hw/rtl/svmp_pkg.sv]
package svmp_pkg;

    // default number of entries in one bank
    localparam int CAPACITY_DEF = 1024;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // action codes on the input port
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_MERGE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // status codes on the result port
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_ORDER    = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    // combine rules for equal ids
    localparam logic [1:0] POOL_SUM = 2'd0;
    localparam logic [1:0] POOL_MAX = 2'd1;
    localparam logic [1:0] POOL_MIN = 2'd2;

    // decoded operation
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_MERGE,
        OP_READ,
        OP_NONE
    } op_t;

    // one classified beat in the queue
    typedef struct packed {
        op_t         op;
        logic        bad_order;
        logic [31:0] voxel_id;
        logic [31:0] voxel_value;
        logic        last_in_tensor;
        logic [9:0]  read_index;
    } item_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MATCH,
        ST_VOXEL_DONE,
        ST_FLUSH_FETCH,
        ST_FLUSH_EMIT,
        ST_READ_WAIT
    } back_state_t;

endpackage

[hw/rtl/svmp_ram.sv]
module svmp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/svmp_queue.sv]
module svmp_queue
    import svmp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output item_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign full    = (fill_reg == CW'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/svmp_front.sv]
module svmp_front
    import svmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] voxel_id,
    input  logic [31:0] voxel_value,
    input  logic        last_in_tensor,
    input  logic [9:0]  read_index,
    input  logic        q_pop,
    output logic        q_empty,
    output item_t       q_head
);

    logic        accept;
    logic        q_full;
    item_t       item;
    op_t         op;
    logic        bad_order;
    logic [31:0] prev_id_reg, prev_id_next;
    logic        have_prev_reg, have_prev_next;

    assign busy   = q_full;
    assign accept = start && !q_full;

    // decode the action
    always_comb
    begin
        case (action)
            ACT_CLEAR: op = OP_CLEAR;
            ACT_MERGE: op = OP_MERGE;
            ACT_READ:  op = OP_READ;
            default:   op = OP_NONE;
        endcase
    end

    // id order check against the last merged id of this tensor
    assign bad_order = have_prev_reg && (voxel_id <= prev_id_reg);

    always_comb
    begin
        item.op             = op;
        item.bad_order      = bad_order;
        item.voxel_id       = voxel_id;
        item.voxel_value    = voxel_value;
        item.last_in_tensor = last_in_tensor;
        item.read_index     = read_index;
    end

    // tracking of the previous id
    always_comb
    begin
        prev_id_next   = prev_id_reg;
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            if (op == OP_CLEAR)
            begin
                prev_id_next   = '0;
                have_prev_next = 1'b0;
            end
            else if (op == OP_MERGE)
            begin
                if (last_in_tensor)
                begin
                    prev_id_next   = '0;
                    have_prev_next = 1'b0;
                end
                else if (!bad_order)
                begin
                    prev_id_next   = voxel_id;
                    have_prev_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_id_reg   <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_id_reg   <= prev_id_next;
            have_prev_reg <= have_prev_next;
        end
    end

    svmp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

endmodule

[hw/rtl/svmp_back.sv]
module svmp_back
    import svmp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  item_t              q_head,
    output logic               q_pop,
    input  logic [1:0]         pool_mode,
    output logic               done,
    output logic [31:0]        entry_id,
    output logic signed [31:0] entry_value,
    output logic [10:0]        entry_count,
    output logic [1:0]         status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(2 * CAPACITY);

    back_state_t state_reg, state_next;
    item_t       cur_reg, cur_next;
    logic          active_reg, active_next;
    logic [CW-1:0] old_count_reg, old_count_next;
    logic [CW-1:0] old_ptr_reg, old_ptr_next;
    logic [CW-1:0] new_count_reg, new_count_next;
    logic          ovf_reg, ovf_next;

    logic          done_reg, done_next;
    logic [31:0]   rid_reg, rid_next;
    logic [31:0]   rval_reg, rval_next;
    logic [10:0]   rcount_reg, rcount_next;
    logic [1:0]    rstat_reg, rstat_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;
    logic [31:0]   d_id, d_val;
    logic          have_old, read_ok;
    logic [AW-1:0] old_base, new_base;

    logic          emit_en;
    logic [31:0]   emit_id, emit_val;

    assign d_id     = rd_data[63:32];
    assign d_val    = rd_data[31:0];
    assign have_old = old_ptr_reg < old_count_reg;
    assign read_ok  = 32'(q_head.read_index) < 32'(old_count_reg);
    assign old_base = active_reg ? AW'(CAPACITY) : '0;
    assign new_base = active_reg ? '0 : AW'(CAPACITY);

    // pool rule for equal ids
    function automatic logic [31:0] pool_combine(input logic [1:0] mode,
                                                 input logic [31:0] stored,
                                                 input logic [31:0] incoming);
        logic signed [32:0] sum;
        logic [31:0]        res;
        sum = 33'(signed'(stored)) + 33'(signed'(incoming));
        case (mode)
            POOL_SUM:
            begin
                if (sum[32] != sum[31])
                begin
                    res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    res = sum[31:0];
                end
            end
            POOL_MAX: res = (signed'(incoming) > signed'(stored)) ? incoming : stored;
            POOL_MIN: res = (signed'(incoming) < signed'(stored)) ? incoming : stored;
            default:  res = stored;
        endcase
        return res;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.op == OP_READ && read_ok)
                    begin
                        state_next = ST_READ_WAIT;
                    end
                    else if (q_head.op == OP_MERGE)
                    begin
                        if (!q_head.bad_order)
                        begin
                            state_next = ST_FETCH;
                        end
                        else if (q_head.last_in_tensor)
                        begin
                            state_next = ST_FLUSH_FETCH;
                        end
                    end
                end
            end
            ST_FETCH:       state_next = have_old ? ST_MATCH : ST_VOXEL_DONE;
            ST_MATCH:       state_next = (d_id < cur_reg.voxel_id) ? ST_FETCH : ST_VOXEL_DONE;
            ST_VOXEL_DONE:  state_next = cur_reg.last_in_tensor ? ST_FLUSH_FETCH : ST_IDLE;
            ST_FLUSH_FETCH: state_next = have_old ? ST_FLUSH_EMIT : ST_IDLE;
            ST_FLUSH_EMIT:  state_next = ST_FLUSH_FETCH;
            ST_READ_WAIT:   state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop          = 1'b0;
        cur_next       = cur_reg;
        active_next    = active_reg;
        old_count_next = old_count_reg;
        old_ptr_next   = old_ptr_reg;
        rd_addr        = old_base + AW'(old_ptr_reg);
        emit_en        = 1'b0;
        emit_id        = cur_reg.voxel_id;
        emit_val       = cur_reg.voxel_value;
        done_next      = 1'b0;
        rid_next       = '0;
        rval_next      = '0;
        rcount_next    = 11'(old_count_reg);
        rstat_next     = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = old_base + AW'(q_head.read_index);
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    case (q_head.op)
                        OP_CLEAR:
                        begin
                            old_count_next = '0;
                            old_ptr_next   = '0;
                            done_next      = 1'b1;
                            rcount_next    = '0;
                        end
                        OP_READ:
                        begin
                            if (!read_ok)
                            begin
                                done_next  = 1'b1;
                                rstat_next = STAT_RANGE;
                            end
                        end
                        OP_MERGE:
                        begin
                            if (q_head.bad_order && !q_head.last_in_tensor)
                            begin
                                done_next  = 1'b1;
                                rstat_next = STAT_ORDER;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (!have_old)
                begin
                    emit_en = 1'b1;
                end
            end
            ST_MATCH:
            begin
                emit_en = 1'b1;
                if (d_id < cur_reg.voxel_id)
                begin
                    emit_id      = d_id;
                    emit_val     = d_val;
                    old_ptr_next = old_ptr_reg + 1'b1;
                end
                else if (d_id == cur_reg.voxel_id)
                begin
                    emit_val     = pool_combine(pool_mode, d_val, cur_reg.voxel_value);
                    old_ptr_next = old_ptr_reg + 1'b1;
                end
            end
            ST_VOXEL_DONE:
            begin
                if (!cur_reg.last_in_tensor)
                begin
                    done_next  = 1'b1;
                    rstat_next = ovf_reg ? STAT_OVERFLOW : STAT_OK;
                end
            end
            ST_FLUSH_FETCH:
            begin
                if (!have_old)
                begin
                    // tensor finished: swap banks
                    active_next    = !active_reg;
                    old_count_next = new_count_reg;
                    old_ptr_next   = '0;
                    done_next      = 1'b1;
                    rcount_next    = 11'(new_count_reg);
                    rstat_next     = cur_reg.bad_order ? STAT_ORDER :
                                     (ovf_reg ? STAT_OVERFLOW : STAT_OK);
                end
            end
            ST_FLUSH_EMIT:
            begin
                emit_en      = 1'b1;
                emit_id      = d_id;
                emit_val     = d_val;
                old_ptr_next = old_ptr_reg + 1'b1;
            end
            ST_READ_WAIT:
            begin
                done_next = 1'b1;
                rid_next  = d_id;
                rval_next = d_val;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // write into the new bank, drop when full
    always_comb
    begin
        wr_en          = emit_en && (new_count_reg < CW'(CAPACITY));
        wr_addr        = new_base + AW'(new_count_reg);
        wr_data        = {emit_id, emit_val};
        new_count_next = new_count_reg;
        ovf_next       = ovf_reg;
        if (wr_en)
        begin
            new_count_next = new_count_reg + 1'b1;
        end
        else if (emit_en)
        begin
            ovf_next = 1'b1;
        end
        if ((state_reg == ST_IDLE && !q_empty && q_head.op == OP_CLEAR) ||
            (state_reg == ST_FLUSH_FETCH && !have_old))
        begin
            new_count_next = '0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            old_count_reg <= '0;
            old_ptr_reg   <= '0;
            new_count_reg <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            old_count_reg <= old_count_next;
            old_ptr_reg   <= old_ptr_next;
            new_count_reg <= new_count_next;
            ovf_reg       <= ovf_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        rid_reg    <= rid_next;
        rval_reg   <= rval_next;
        rcount_reg <= rcount_next;
        rstat_reg  <= rstat_next;
    end

    assign done        = done_reg;
    assign entry_id    = rid_reg;
    assign entry_value = signed'(rval_reg);
    assign entry_count = rcount_reg;
    assign status      = rstat_reg;

    svmp_ram #(
        .WIDTH (64),
        .DEPTH (2 * CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // counts stay within one bank
    assert property (@(posedge clk) disable iff (!rst_n)
        (new_count_reg <= CW'(CAPACITY)) && (old_count_reg <= CW'(CAPACITY)))
        else $error("bank count beyond capacity");

    // the read pointer never passes the stored list
    assert property (@(posedge clk) disable iff (!rst_n)
        old_ptr_reg <= old_count_reg)
        else $error("old pointer past old count");

    // merge writes never land in the completed bank
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((wr_addr >= AW'(CAPACITY)) == !active_reg))
        else $error("write into active bank");

    // an out of range read returns zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rstat_reg == STAT_RANGE) |-> (rid_reg == '0 && rval_reg == '0))
        else $error("range error with nonzero data");

    // a flush emit always moves on to a flush fetch without giving a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH_EMIT) |=> (state_reg == ST_FLUSH_FETCH && !done_reg))
        else $error("flush sequencing broken");

endmodule

[hw/rtl/sparse_voxel_merge_pool.sv]
// Sorted sparse voxel list with merge and pooling. Issue a command by raising
// start while busy is low; busy is high only while the two-beat command queue is
// full. Each command gives exactly one result beat, marked by done for one cycle,
// which the receiver must take as it comes. A clear or an out-of-range read ends
// in the back end's idle state; a valid read adds a wait state for the registered
// RAM read. A merge beat passes fetch and match for each stored entry of lower
// id, then the voxel itself; the last voxel of a tensor adds a flush fetch and
// emit per remaining entry, then the bank swap. Stored-entry reads use the single
// read port of the entry RAM. Reads always see the completed list, never a merge
// in progress. pool_mode is written through its own valid/ready port, always
// ready; the user must write it only while idle, which the block does not check.
module sparse_voxel_merge_pool
    import svmp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [31:0]        voxel_id,
    input  logic signed [31:0] voxel_value,
    input  logic               last_in_tensor,
    input  logic [9:0]         read_index,
    output logic               done,
    output logic [31:0]        entry_id,
    output logic signed [31:0] entry_value,
    output logic [10:0]        entry_count,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         pool_mode
);

    logic       q_pop;
    logic       q_empty;
    item_t      q_head;
    logic [1:0] pool_mode_reg, pool_mode_next;

    // configuration register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pool_mode_next = pool_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            pool_mode_next = pool_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_mode_reg <= POOL_SUM;
        end
        else
        begin
            pool_mode_reg <= pool_mode_next;
        end
    end

    svmp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .voxel_id       (voxel_id),
        .voxel_value    (voxel_value),
        .last_in_tensor (last_in_tensor),
        .read_index     (read_index),
        .q_pop          (q_pop),
        .q_empty        (q_empty),
        .q_head         (q_head)
    );

    svmp_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pool_mode   (pool_mode_reg),
        .done        (done),
        .entry_id    (entry_id),
        .entry_value (entry_value),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule
